/* src/pil_pkg.sv */
// Shared types and constants for the positional insert/remove list.
`default_nettype none

package pil_pkg;

	// List geometry
	localparam int DEPTH      = 16;
	localparam int WORD_WIDTH = 32;

	// Fixed port widths
	localparam int ACT_W  = 2;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int ECNT_W = 5;

	// Derived widths
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// What one cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LOWER,
		CELL_FROM_UPPER
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* src/positional_insert_remove_list.sv */
// Top level of the positional insert/remove list: decode, cell chain, result register.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one beat per operation: action
//    (insert, remove, read), position and value. Insert places value at
//    position 0..count and moves later entries up; remove returns the entry at
//    position and moves later entries down; read returns it unchanged.
//  - Output channel (out_valid/out_ready) returns exactly one beat per input
//    beat: data_out, status (ok, out of range, full), entry_count, list_empty.
//  - The result is registered: it appears in the output register the cycle
//    after the input beat. Throughput is one item per cycle while the receiver
//    takes each result; every cell of the chain shifts to its neighbor in the
//    same edge, whatever the position.
//  - When the receiver stalls, the single result register holds its beat and
//    in_ready drops until that beat is taken; in_ready is high whenever the
//    result register is empty or being emptied in the same cycle.
//  - Reset (arst_n low) empties the list and the result register. Stored words
//    need no clearing: only entries below the count are ever read.
`default_nettype none

module positional_insert_remove_list (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [pil_pkg::ACT_W-1:0]           action,
	input  wire logic [pil_pkg::POS_W-1:0]           position,
	input  wire logic signed [pil_pkg::DATA_W-1:0]   value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [pil_pkg::DATA_W-1:0]        data_out,
	output logic [pil_pkg::STAT_W-1:0]               status,
	output logic [pil_pkg::ECNT_W-1:0]               entry_count,
	output logic                                     list_empty
);

	logic [pil_pkg::CNT_W-1:0]               count_q;
	logic                                    out_valid_q;
	logic signed [pil_pkg::DATA_W-1:0]       data_out_q;
	logic [pil_pkg::STAT_W-1:0]              status_q;
	logic [pil_pkg::ECNT_W-1:0]              entry_count_q;
	logic                                    list_empty_q;

	logic                                    in_fire;
	logic [pil_pkg::CMP_W-1:0]               pos_ext;
	logic [pil_pkg::CMP_W-1:0]               cnt_ext;
	logic                                    insert_ok;
	logic                                    remove_ok;
	logic                                    read_ok;
	logic [pil_pkg::STAT_W-1:0]              status_nx;
	logic [pil_pkg::CNT_W-1:0]               count_nx;
	logic signed [pil_pkg::DATA_W-1:0]       data_nx;
	logic signed [pil_pkg::WORD_WIDTH-1:0]   ins_word;
	logic signed [pil_pkg::WORD_WIDTH-1:0]   rd_word;
	logic signed [pil_pkg::WORD_WIDTH-1:0]   words [pil_pkg::DEPTH];
	pil_pkg::cell_ctl_t                      ctls  [pil_pkg::DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign pos_ext  = pil_pkg::CMP_W'(position);
	assign cnt_ext  = pil_pkg::CMP_W'(count_q);
	assign ins_word = pil_pkg::WORD_WIDTH'(value);
	assign rd_word  = words[position[pil_pkg::IDX_W-1:0]];

	// Range and capacity checks, status and next count
	always_comb begin
		insert_ok = 1'b0;
		remove_ok = 1'b0;
		read_ok   = 1'b0;
		status_nx = pil_pkg::ST_OK;
		count_nx  = count_q;
		unique case (action)
			pil_pkg::ACT_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_nx = pil_pkg::ST_RANGE;
				end else if (cnt_ext == pil_pkg::CMP_W'(pil_pkg::DEPTH)) begin
					status_nx = pil_pkg::ST_FULL;
				end else begin
					insert_ok = 1'b1;
					count_nx  = count_q + pil_pkg::CNT_W'(1);
				end
			end
			pil_pkg::ACT_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					status_nx = pil_pkg::ST_RANGE;
				end else begin
					remove_ok = 1'b1;
					count_nx  = count_q - pil_pkg::CNT_W'(1);
				end
			end
			pil_pkg::ACT_READ: begin
				if (pos_ext >= cnt_ext) begin
					status_nx = pil_pkg::ST_RANGE;
				end else begin
					read_ok = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Word leaving or read: sign-extended from the stored width
	assign data_nx = (remove_ok || read_ok) ? pil_pkg::DATA_W'(rd_word)
		: '0;

	// Cell chain: per-cell command from its place relative to the position
	for (genvar i = 0; i < pil_pkg::DEPTH; i++) begin : g_cell
		localparam logic [pil_pkg::CMP_W-1:0] IDX = pil_pkg::CMP_W'(i);
		localparam int LO = (i > 0) ? i - 1 : i;
		localparam int HI = (i < pil_pkg::DEPTH - 1) ? i + 1 : i;

		always_comb begin
			ctls[i].op = pil_pkg::CELL_HOLD;
			if (in_fire && insert_ok) begin
				if (IDX == pos_ext) begin
					ctls[i].op = pil_pkg::CELL_LOAD;
				end else if (IDX > pos_ext) begin
					ctls[i].op = pil_pkg::CELL_FROM_LOWER;
				end
			end else if (in_fire && remove_ok) begin
				if (IDX >= pos_ext) begin
					ctls[i].op = pil_pkg::CELL_FROM_UPPER;
				end
			end
		end

		pil_cell u_cell (
			.clk        (clk),
			.ctl        (ctls[i]),
			.ins_word   (ins_word),
			.lower_word (words[LO]),
			.upper_word (words[HI]),
			.word       (words[i])
		);
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			count_q <= count_nx;
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_out_q    <= data_nx;
			status_q      <= status_nx;
			entry_count_q <= pil_pkg::ECNT_W'(count_nx);
			list_empty_q  <= (count_nx == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign data_out    = data_out_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign list_empty  = list_empty_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pil_pkg::CNT_W'(pil_pkg::DEPTH))
		else $error("entry count above depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (list_empty_q == (entry_count_q == '0)))
		else $error("empty flag disagrees with count");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && insert_ok) |=> (count_q == $past(count_q) + pil_pkg::CNT_W'(1)))
		else $error("insert did not grow the list");

	a_error_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && status_nx != pil_pkg::ST_OK) |=> (count_q == $past(count_q)))
		else $error("rejected beat changed the count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (entry_count_q == pil_pkg::ECNT_W'(count_q)))
		else $error("reported count differs from list count");
`endif

endmodule

`default_nettype wire

/* src/pil_cell.sv */
// One storage cell of the list: holds a word, loads, or takes a neighbor's word.
`default_nettype none

module pil_cell (
	input  wire logic                                   clk,
	input  wire pil_pkg::cell_ctl_t                     ctl,
	input  wire logic signed [pil_pkg::WORD_WIDTH-1:0]  ins_word,
	input  wire logic signed [pil_pkg::WORD_WIDTH-1:0]  lower_word,
	input  wire logic signed [pil_pkg::WORD_WIDTH-1:0]  upper_word,
	output logic signed [pil_pkg::WORD_WIDTH-1:0]       word
);

	logic signed [pil_pkg::WORD_WIDTH-1:0] word_q;

	// Word register with neighbor shift
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			pil_pkg::CELL_HOLD:       word_q <= word_q;
			pil_pkg::CELL_LOAD:       word_q <= ins_word;
			pil_pkg::CELL_FROM_LOWER: word_q <= lower_word;
			pil_pkg::CELL_FROM_UPPER: word_q <= upper_word;
			default:                  word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

`default_nettype wire
